[sv/indexed_list_engine_core_assert.svh]
// ----------------------------------------------------------------------------
// indexed_list_engine_core_assert
// Assertion macros for the indexed list engine.
// Each macro names a clock and an active-low reset that must be visible
// at the place of use: clk and rst_n.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_CORE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ILE_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("indexed list engine: same-cycle check failed");

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("indexed list engine: next-cycle check failed");

`else

`define ILE_ASSERT_IMP(label, ante, cons)
`define ILE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[sv/ile_pkg.sv]
// ----------------------------------------------------------------------------
// ile_pkg
// Shared constants, operation codes and cell control type of the indexed
// list engine.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY_DEF = 1024;

    localparam int OP_W      = 3;
    localparam int POS_W     = 16;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 11;

    localparam logic [OP_W-1:0] OP_READ       = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_AT     = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;        // open a slot at k, shift upper cells up
        logic rem;        // close slot k, shift upper cells down
        logic load_tap;   // copy each entry into its read tap
        logic shift_tap;  // move the read taps one cell toward the head
    } cell_ctrl_t;

endpackage

[sv/ile_cell.sv]
// ----------------------------------------------------------------------------
// ile_cell
// One slot of the list: holds an entry and a read tap, and trades data with
// its two neighbors on insert, remove and read-out.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int CW  = 11,
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  ile_pkg::cell_ctrl_t        ctrl,
    input  logic [CW-1:0]              k,
    input  logic [ile_pkg::VAL_W-1:0]  w,
    input  logic [ile_pkg::VAL_W-1:0]  prev_entry,
    input  logic [ile_pkg::VAL_W-1:0]  next_entry,
    input  logic [ile_pkg::VAL_W-1:0]  next_tap,
    output logic [ile_pkg::VAL_W-1:0]  entry,
    output logic [ile_pkg::VAL_W-1:0]  tap
);

    localparam logic [CW-1:0] IDX_C = CW'(IDX);

    logic [ile_pkg::VAL_W-1:0] entry_reg;
    logic [ile_pkg::VAL_W-1:0] entry_next;
    logic [ile_pkg::VAL_W-1:0] tap_reg;
    logic [ile_pkg::VAL_W-1:0] tap_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (IDX_C > k)
                entry_next = prev_entry;
            else if (IDX_C == k)
                entry_next = w;
        end
        else if (ctrl.rem)
        begin
            if (IDX_C >= k)
                entry_next = next_entry;
        end
    end

    always_comb
    begin
        tap_next = tap_reg;
        if (ctrl.load_tap)
            tap_next = entry_reg;
        else if (ctrl.shift_tap)
            tap_next = next_tap;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tap_reg   <= tap_next;
    end

    assign entry = entry_reg;
    assign tap   = tap_reg;

endmodule

[sv/indexed_list_engine_core.sv]
// ----------------------------------------------------------------------------
// indexed_list_engine_core
// Ordered list of signed 32-bit values with 1-based positions, kept in a
// chain of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (operation, position, value) enter on in_valid / in_stall;
//   each gives one result word (read_value, ok, count) on out_valid /
//   out_stall. Operations: read, insert at head, insert at tail, insert at
//   position, remove at position.
//   Insert, remove, failed reads and unknown codes are handled after
//   acceptance as follows: the word is registered, then the operation
//   is done, with every cell shifting at once for an insert or remove.
//   A read at position p copies the entries into a tap chain that moves
//   one cell toward the head per cycle; the tap at the head is the result.
//   One word is in work at a time; the next is taken in the cycle its
//   result is taken, or at once if the output register is empty.
//   Reset clears the count and the control state; entry contents are
//   undefined until written, and only positions 1..count are ever read.
//   A stalled result holds in the output register and the input side
//   stalls until it is taken.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_core_assert.svh"

module indexed_list_engine_core #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ile_pkg::OP_W-1:0]              operation,
    input  logic signed [ile_pkg::POS_W-1:0]      position,
    input  logic signed [ile_pkg::VAL_W-1:0]      value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ile_pkg::VAL_W-1:0]      read_value,
    output logic                                  ok,
    output logic [ile_pkg::CNT_OUT_W-1:0]         count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EXEC  = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]                      state_reg;
    logic [1:0]                      state_next;
    logic [ile_pkg::OP_W-1:0]        op_reg;
    logic [ile_pkg::POS_W-1:0]       pos_reg;
    logic [ile_pkg::VAL_W-1:0]       val_reg;
    logic [CW-1:0]                   count_reg;
    logic [CW-1:0]                   count_next;
    logic [CW-1:0]                   cnt_reg;
    logic [CW-1:0]                   cnt_next;
    logic                            out_valid_reg;
    logic [ile_pkg::VAL_W-1:0]       out_data_reg;
    logic                            out_ok_reg;
    logic [ile_pkg::CNT_OUT_W-1:0]   out_count_reg;

    logic            pos_pos;
    logic [LW-1:0]   pos_mag;
    logic [LW-1:0]   count_ext;
    logic            in_range;
    logic [CW-1:0]   pos_m1;
    logic            full;
    logic            is_ins;
    logic [CW-1:0]   k;
    logic            do_ins;
    logic            do_rem;
    logic            do_read;
    logic            in_take;
    logic            out_take;
    logic            finish_exec;
    logic            finish_read;

    ile_pkg::cell_ctrl_t       ctrl;
    logic [ile_pkg::VAL_W-1:0] entry_w [CAPACITY];
    logic [ile_pkg::VAL_W-1:0] tap_w   [CAPACITY];

    // ---------------------------------------------------------------- decode
    assign pos_pos   = !pos_reg[ile_pkg::POS_W-1] && (pos_reg != '0);
    assign pos_mag   = LW'(pos_reg[ile_pkg::POS_W-2:0]);
    assign count_ext = LW'(count_reg);
    assign in_range  = pos_pos && (pos_mag <= count_ext);
    assign pos_m1    = CW'(pos_mag - LW'(1));
    assign full      = (count_reg == CAP_C);
    assign is_ins    = (op_reg == ile_pkg::OP_INS_HEAD) || (op_reg == ile_pkg::OP_INS_TAIL)
                    || (op_reg == ile_pkg::OP_INS_AT);

    always_comb
    begin
        k = '0;
        if (op_reg == ile_pkg::OP_INS_TAIL)
            k = count_reg;
        else if (op_reg == ile_pkg::OP_INS_AT)
        begin
            // past the end goes to the tail, zero or below to the head
            if (pos_pos && (pos_mag > count_ext))
                k = count_reg;
            else if (pos_pos)
                k = pos_m1;
        end
        else if (op_reg == ile_pkg::OP_REMOVE)
            k = pos_m1;
    end

    assign do_ins  = is_ins && !full;
    assign do_rem  = (op_reg == ile_pkg::OP_REMOVE) && in_range;
    assign do_read = (op_reg == ile_pkg::OP_READ) && in_range;

    // ------------------------------------------------------------- handshake
    assign out_take    = out_valid_reg && !out_stall;
    assign in_stall    = !((state_reg == ST_IDLE) && (!out_valid_reg || out_take));
    assign in_take     = in_valid && !in_stall;
    assign finish_exec = (state_reg == ST_EXEC) && !do_read;
    assign finish_read = (state_reg == ST_SHIFT) && (cnt_reg == '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = do_read ? ST_SHIFT : ST_IDLE;
            end
            ST_SHIFT:
            begin
                if (cnt_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if ((state_reg == ST_EXEC) && do_ins)
            count_next = count_reg + CW'(1);
        else if ((state_reg == ST_EXEC) && do_rem)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if ((state_reg == ST_EXEC) && do_read)
            cnt_next = pos_m1;
        else if ((state_reg == ST_SHIFT) && (cnt_reg != '0))
            cnt_next = cnt_reg - CW'(1);
    end

    always_comb
    begin
        ctrl.ins       = (state_reg == ST_EXEC) && do_ins;
        ctrl.rem       = (state_reg == ST_EXEC) && do_rem;
        ctrl.load_tap  = (state_reg == ST_EXEC) && do_read;
        ctrl.shift_tap = (state_reg == ST_SHIFT) && (cnt_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            if (finish_exec || finish_read)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // hold the accepted word and the result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= operation;
            pos_reg <= position;
            val_reg <= value;
        end
        if (finish_exec)
        begin
            out_data_reg  <= '1;
            out_ok_reg    <= do_ins || do_rem;
            out_count_reg <= ile_pkg::CNT_OUT_W'(count_next);
        end
        else if (finish_read)
        begin
            out_data_reg  <= tap_w[0];
            out_ok_reg    <= 1'b1;
            out_count_reg <= ile_pkg::CNT_OUT_W'(count_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_data_reg;
    assign ok         = out_ok_reg;
    assign count      = out_count_reg;

    // ----------------------------------------------------------- cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [ile_pkg::VAL_W-1:0] prev_e;
        logic [ile_pkg::VAL_W-1:0] next_e;
        logic [ile_pkg::VAL_W-1:0] next_t;

        if (i == 0)
        begin : g_head
            assign prev_e = entry_w[i];
        end
        else
        begin : g_mid
            assign prev_e = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_e = entry_w[i];
            assign next_t = tap_w[i];
        end
        else
        begin : g_body
            assign next_e = entry_w[i+1];
            assign next_t = tap_w[i+1];
        end

        ile_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .k          (k),
            .w          (val_reg),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .next_tap   (next_t),
            .entry      (entry_w[i]),
            .tap        (tap_w[i])
        );
    end

    // ------------------------------------------------------------ assertions
    `ILE_ASSERT_NEXT(a_take_starts_exec, in_valid && !in_stall, state_reg == ST_EXEC)
    `ILE_ASSERT_NEXT(a_ins_counts_up, (state_reg == ST_EXEC) && do_ins, count_reg == $past(count_reg) + CW'(1))
    `ILE_ASSERT_NEXT(a_tap_walk, (state_reg == ST_SHIFT) && (cnt_reg != '0), cnt_reg == $past(cnt_reg) - CW'(1))
    `ILE_ASSERT_IMP(a_fail_reads_minus_one, out_valid_reg && !out_ok_reg, out_data_reg == '1)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the indexed list engine. A directed table covers
// the empty list, value extremes, head/tail/position inserts, out-of-range
// reads and removes, and the unused operation codes. A random load then
// mixes operations on a short list, grows the list to capacity, tries
// inserts while full and shrinks it again. Each result word is checked
// against the table's expected word or a local list model. Input bursts and
// output stalls are random, with two long output hold-offs that back it up.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CAPACITY     = ile_pkg::CAPACITY_DEF;
    localparam int NUM_ROWS     = 25;
    localparam int RANDOM_ITEMS = 1350;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [ile_pkg::OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [ile_pkg::OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [ile_pkg::OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [ile_pkg::VAL_W-1:0] READ_MISS = -32'sd1;
    localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [ile_pkg::VAL_W-1:0] VAL_MIN   = 32'sh8000_0000;

    typedef struct packed {
        logic signed [ile_pkg::VAL_W-1:0] read_value;
        logic                             ok;
        logic [ile_pkg::CNT_OUT_W-1:0]    count;
    } list_result_t;

    typedef struct {
        logic [ile_pkg::OP_W-1:0]         op;
        logic signed [ile_pkg::POS_W-1:0] pos;
        logic signed [ile_pkg::VAL_W-1:0] val;
        bit                               typed;
        list_result_t                     want;
    } directed_row_t;

    typedef enum {PH_MIXED, PH_GROW, PH_FULL, PH_SHRINK} load_phase_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 in_valid;
    logic                                 in_stall;
    logic [ile_pkg::OP_W-1:0]             operation;
    logic signed [ile_pkg::POS_W-1:0]     position;
    logic signed [ile_pkg::VAL_W-1:0]     value;
    logic                                 out_valid;
    logic                                 out_stall;
    logic signed [ile_pkg::VAL_W-1:0]     read_value;
    logic                                 ok;
    logic [ile_pkg::CNT_OUT_W-1:0]        count;

    logic signed [ile_pkg::VAL_W-1:0]     list_mem [CAPACITY];
    int                                   list_len;
    list_result_t                         pending_results [$];
    directed_row_t                        plan [NUM_ROWS];
    int                                   words_in;
    int                                   results_seen;
    int                                   burst_left;
    int                                   mismatches;

    indexed_list_engine_core #(
        .CAPACITY   (CAPACITY)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .position   (position),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .ok         (ok),
        .count      (count)
    );

    always #1 clk = ~clk;

    // Apply one operation to the local list and return the result word.
    function automatic list_result_t apply_list_op(
        input logic [ile_pkg::OP_W-1:0]         op,
        input logic signed [ile_pkg::POS_W-1:0] pos,
        input logic signed [ile_pkg::VAL_W-1:0] val
    );
        list_result_t res;
        int           p;
        int           slot;
        bit           in_range;
        p = int'(pos);
        in_range = (p >= 1) && (p <= list_len);
        res.read_value = READ_MISS;
        res.ok = 1'b0;
        slot = -1;
        case (op)
            ile_pkg::OP_READ:
                if (in_range)
                begin
                    res.read_value = list_mem[p - 1];
                    res.ok = 1'b1;
                end
            ile_pkg::OP_INS_HEAD: slot = 0;
            ile_pkg::OP_INS_TAIL: slot = list_len;
            ile_pkg::OP_INS_AT:
                slot = (p <= 0) ? 0 : (p > list_len) ? list_len : p - 1;
            ile_pkg::OP_REMOVE:
                if (in_range)
                begin
                    for (int i = p - 1; i < list_len - 1; i++)
                        list_mem[i] = list_mem[i + 1];
                    list_len--;
                    res.ok = 1'b1;
                end
            default: ;
        endcase
        // full list: the insert is dropped
        if (slot >= 0 && list_len < CAPACITY)
        begin
            for (int i = list_len; i > slot; i--)
                list_mem[i] = list_mem[i - 1];
            list_mem[slot] = val;
            list_len++;
            res.ok = 1'b1;
        end
        res.count = ile_pkg::CNT_OUT_W'(list_len);
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR: %s", msg);
    endtask

    // Offer one word, hold it until taken, then record its expected result.
    task automatic send_word(
        input logic [ile_pkg::OP_W-1:0]         op,
        input logic signed [ile_pkg::POS_W-1:0] pos,
        input logic signed [ile_pkg::VAL_W-1:0] val,
        input bit                               typed,
        input list_result_t                     typed_res
    );
        list_result_t res;
        int           gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        position  <= pos;
        value     <= val;
        do
            @(posedge clk);
        while (in_stall);
        res = apply_list_op(op, pos, val);
        pending_results.push_back(typed ? typed_res : res);
        words_in++;
    endtask

    // Output side: random stall pattern, plus two long hold-offs.
    initial
    begin : out_stall_gen
        int run_left;
        int mode;
        int hold_left;
        int holds_done;
        out_stall = 1'b0;
        run_left = 0;
        mode = 0;
        hold_left = 0;
        holds_done = 0;
        forever
        begin
            @(negedge clk);
            if ((holds_done == 0 && words_in >= 40) || (holds_done == 1 && words_in >= 700))
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (run_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    run_left = $urandom_range(5, 60);
                end
                run_left--;
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 4) == 0);
                    2: out_stall <= ($urandom_range(0, 9) < 6);
                    default: out_stall <= run_left[0];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        list_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing pending", results_seen));
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.read_value)
                    flag_error($sformatf("result %0d read_value exp %0d got %0d",
                        results_seen, want.read_value, read_value));
                if (ok !== want.ok)
                    flag_error($sformatf("result %0d ok exp %0b got %0b",
                        results_seen, want.ok, ok));
                if (count !== want.count)
                    flag_error($sformatf("result %0d count exp %0d got %0d",
                        results_seen, want.count, count));
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin : stimulus
        load_phase_t                      phase;
        logic [ile_pkg::OP_W-1:0]         op;
        logic signed [ile_pkg::POS_W-1:0] pos;
        logic signed [ile_pkg::VAL_W-1:0] val;
        int                               item_no;
        int                               phase_items;
        int                               r;
        int                               rd_pct;
        int                               ins_pct;

        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = ile_pkg::OP_READ;
        position = '0;
        value = '0;
        list_len = 0;
        words_in = 0;
        results_seen = 0;
        burst_left = 0;
        mismatches = 0;

        plan = '{
            '{ile_pkg::OP_READ,     16'sd1,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd0}},
            '{ile_pkg::OP_REMOVE,   16'sd1,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd0}},
            '{ile_pkg::OP_INS_HEAD, 16'sd0,    VAL_MAX,   1'b1, '{READ_MISS, 1'b1, 11'd1}},
            '{ile_pkg::OP_INS_TAIL, 16'sd0,    VAL_MIN,   1'b1, '{READ_MISS, 1'b1, 11'd2}},
            '{ile_pkg::OP_READ,     16'sd1,    32'sd0,    1'b1, '{VAL_MAX,   1'b1, 11'd2}},
            '{ile_pkg::OP_READ,     16'sd2,    32'sd0,    1'b1, '{VAL_MIN,   1'b1, 11'd2}},
            // position zero and most negative go to the head, largest to the tail
            '{ile_pkg::OP_INS_AT,   16'sd0,    32'sd5,    1'b1, '{READ_MISS, 1'b1, 11'd3}},
            '{ile_pkg::OP_INS_AT,   16'sh8000, READ_MISS, 1'b1, '{READ_MISS, 1'b1, 11'd4}},
            '{ile_pkg::OP_INS_AT,   16'sh7FFF, 32'sd0,    1'b1, '{READ_MISS, 1'b1, 11'd5}},
            '{ile_pkg::OP_INS_AT,   16'sd3,    32'sd123,  1'b1, '{READ_MISS, 1'b1, 11'd6}},
            '{ile_pkg::OP_READ,     16'sd3,    32'sd0,    1'b0, '0},
            '{ile_pkg::OP_READ,     16'sd0,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_READ,     16'shFFFF, 32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_READ,     16'sd7,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_READ,     16'sh7FFF, 32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{OP_RSVD_5,            16'sd1,    32'sd99,   1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{OP_RSVD_6,            16'sd2,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{OP_RSVD_7,            16'sh8000, READ_MISS, 1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_REMOVE,   16'sd0,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_REMOVE,   16'sd7,    32'sd0,    1'b1, '{READ_MISS, 1'b0, 11'd6}},
            '{ile_pkg::OP_REMOVE,   16'sd6,    32'sd0,    1'b1, '{READ_MISS, 1'b1, 11'd5}},
            '{ile_pkg::OP_REMOVE,   16'sd1,    32'sd0,    1'b1, '{READ_MISS, 1'b1, 11'd4}},
            '{ile_pkg::OP_REMOVE,   16'sd2,    32'sd0,    1'b1, '{READ_MISS, 1'b1, 11'd3}},
            '{ile_pkg::OP_READ,     16'sd2,    32'sd0,    1'b0, '0},
            '{ile_pkg::OP_READ,     16'sd3,    32'sd0,    1'b0, '0}
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++)
            send_word(plan[i].op, plan[i].pos, plan[i].val, plan[i].typed, plan[i].want);

        // Mix on a short list, grow to capacity, hammer the full list, shrink.
        phase = PH_MIXED;
        item_no = 0;
        phase_items = 0;
        while (!(phase == PH_SHRINK && item_no >= RANDOM_ITEMS && phase_items >= 60))
        begin
            case (phase)
                PH_MIXED:
                    if (item_no >= 150)
                    begin
                        phase = PH_GROW;
                        phase_items = 0;
                    end
                PH_GROW:
                    if (list_len == CAPACITY)
                    begin
                        phase = PH_FULL;
                        phase_items = 0;
                    end
                PH_FULL:
                    if (phase_items >= 16)
                    begin
                        phase = PH_SHRINK;
                        phase_items = 0;
                    end
                default: ;
            endcase

            case (phase)
                PH_MIXED:
                begin
                    rd_pct = 15;
                    ins_pct = (list_len > 32) ? 25 : 60;
                end
                PH_GROW:
                begin
                    rd_pct = 4;
                    ins_pct = 93;
                end
                PH_FULL:
                begin
                    rd_pct = 20;
                    ins_pct = 60;
                end
                default:
                begin
                    rd_pct = 12;
                    ins_pct = 18;
                end
            endcase

            r = $urandom_range(0, 99);
            if (r < rd_pct)
                op = ile_pkg::OP_READ;
            else if (r < rd_pct + ins_pct)
                case ($urandom_range(0, 2))
                    0: op = ile_pkg::OP_INS_HEAD;
                    1: op = ile_pkg::OP_INS_TAIL;
                    default: op = ile_pkg::OP_INS_AT;
                endcase
            else
                op = ile_pkg::OP_REMOVE;
            if ($urandom_range(0, 24) == 0)
                case ($urandom_range(0, 2))
                    0: op = OP_RSVD_5;
                    1: op = OP_RSVD_6;
                    default: op = OP_RSVD_7;
                endcase

            if ($urandom_range(0, 9) == 0)
                pos = ile_pkg::POS_W'($urandom);
            else if (op == ile_pkg::OP_INS_AT)
                pos = ile_pkg::POS_W'($urandom_range(0, list_len + 1));
            else if (list_len == 0)
                pos = 16'sd1;
            else if (phase == PH_FULL)
                pos = ile_pkg::POS_W'($urandom_range(list_len - 4, list_len + 1));
            else
                pos = ile_pkg::POS_W'($urandom_range(1, list_len));

            case ($urandom_range(0, 19))
                0: val = VAL_MAX;
                1: val = VAL_MIN;
                2: val = READ_MISS;
                default: val = $urandom;
            endcase

            send_word(op, pos, val, 1'b0, '0);
            item_no++;
            phase_items++;
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // catch any stray word after the last one
        repeat (CAPACITY + 8) @(posedge clk);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
